// File: sv/mmaq_pkg.sv
// mmaq_pkg: shared types, codes and the kind-to-length decode
// for the midi message assembler queue; no dependencies
`default_nettype none

package mmaq_pkg;

   // operation codes on the request channel
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_READ = 1'b1;

   // byte reserved as an empty mark on the wire, always ignored
   localparam logic [7:0] BYTE_IGNORE = 8'hFF;

   localparam int unsigned KIND_W  = 4;
   localparam int unsigned CHAN_W  = 4;
   localparam int unsigned COUNT_W = 2;
   localparam int unsigned DATA_W  = 7;

   // one stored message, 24 bits
   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [CHAN_W-1:0]  chan;
      logic [COUNT_W-1:0] count;
      logic [DATA_W-1:0]  data_first;
      logic [DATA_W-1:0]  data_second;
   } msg_type;

   localparam int unsigned MSG_W = $bits(msg_type);

   // number of data bytes that follow a status byte of the given kind
   function automatic logic [COUNT_W-1:0] count_for_kind(input logic [KIND_W-1:0] kind);
      logic [COUNT_W-1:0] n;
      case (kind)
         4'h8, 4'h9, 4'hA, 4'hB, 4'hE: n = 2'd2;
         4'hC, 4'hD:                   n = 2'd1;
         default:                      n = 2'd0;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

// File: sv/mmaq_ram.sv
// mmaq_ram: generic single-write, single-read ram with registered read data
// no package dependencies
`default_nettype none

module mmaq_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next enabled read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: sv/midi_message_assembler_queue_unit.sv
// the response beat to an accepted request beat is registered and appears in the cycle after it
// throughput: one beat per cycle unless rsp_ready stalls; one ram write or read a cycle
// a read fetches its slot from the ram in the accept cycle, the registered read data
// forms the response; reset is synchronous, clears pointers, occupancy and assembly
// state, ram contents need no clearing since occupancy tracks which slots hold messages
`default_nettype none

module midi_message_assembler_queue_unit #(
   parameter int unsigned MSG_DEPTH = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request channel
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_operation,
   input  wire logic [7:0]                   req_byte_in,
   // response channel
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic                              rsp_accepted,
   output logic                              rsp_msg_valid,
   output logic [mmaq_pkg::KIND_W-1:0]       rsp_msg_kind,
   output logic [mmaq_pkg::CHAN_W-1:0]       rsp_channel,
   output logic [mmaq_pkg::COUNT_W-1:0]      rsp_data_count,
   output logic [mmaq_pkg::DATA_W-1:0]       rsp_data_first,
   output logic [mmaq_pkg::DATA_W-1:0]       rsp_data_second
);

   import mmaq_pkg::*;

   localparam int unsigned PTR_W = $clog2(MSG_DEPTH);
   localparam int unsigned CNT_W = $clog2(MSG_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(MSG_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MSG_DEPTH);

   // ring pointers and occupancy: completed, unread messages sit in a
   // contiguous run from rd_ptr up to wr_ptr-1
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] used_ff, used_in;

   // message under assembly in the write slot; it goes to the ram once complete
   logic               asm_started_ff, asm_started_in;
   msg_type            asm_ff, asm_in;
   logic [COUNT_W-1:0] fill_ff, fill_in;

   // response stage
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_accepted_ff, rsp_accepted_in;
   logic rsp_hit_ff, rsp_hit_in;

   logic             req_fire;
   logic             is_push;
   logic             is_read;
   logic             full;
   logic             nonempty;
   logic             complete;
   logic             pop;
   logic             ram_wr_en;
   logic             ram_rd_en;
   logic [MSG_W-1:0] ram_rd_data;
   msg_type          rd_msg;

   // the response register frees up when empty or when drained this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign is_push   = req_fire && (req_operation == OP_PUSH);
   assign is_read   = req_fire && (req_operation == OP_READ);
   assign full      = (used_ff == FULL_CNT);
   assign nonempty  = (used_ff != '0);

   always_comb begin
      asm_started_in  = asm_started_ff;
      asm_in          = asm_ff;
      fill_in         = fill_ff;
      complete        = 1'b0;
      pop             = 1'b0;
      rsp_accepted_in = 1'b0;
      rsp_hit_in      = 1'b0;

      if (is_push) begin
         if (req_byte_in == BYTE_IGNORE) begin
            // empty mark: consumed, nothing changes, even when full
            rsp_accepted_in = 1'b1;
         end else if (!full) begin
            rsp_accepted_in = 1'b1;
            if (req_byte_in[7]) begin
               // status byte starts or restarts the write slot
               asm_in.kind        = req_byte_in[7:4];
               asm_in.chan        = req_byte_in[3:0];
               asm_in.count       = count_for_kind(req_byte_in[7:4]);
               asm_in.data_first  = '0;
               asm_in.data_second = '0;
               fill_in            = '0;
               asm_started_in     = 1'b1;
               complete           = (asm_in.count == '0);
            end else if (asm_started_ff) begin
               // data byte; stray data with no started message is dropped
               if (fill_ff[0]) begin
                  asm_in.data_second = req_byte_in[DATA_W-1:0];
               end else begin
                  asm_in.data_first = req_byte_in[DATA_W-1:0];
               end
               fill_in  = fill_ff + COUNT_W'(1);
               complete = (fill_in == asm_ff.count);
            end
            if (complete) begin
               asm_started_in = 1'b0;
            end
         end
      end

      if (is_read && nonempty) begin
         pop        = 1'b1;
         rsp_hit_in = 1'b1;
      end
   end

   // pushes and reads never share a cycle, so the ram sees no same-slot overlap
   assign ram_wr_en = complete;
   assign ram_rd_en = pop;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      used_in   = used_ff;
      if (complete) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
         used_in   = used_ff + CNT_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
         used_in   = used_ff - CNT_W'(1);
      end
   end

   assign rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         used_ff        <= '0;
         asm_started_ff <= 1'b0;
         fill_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         wr_ptr_ff      <= wr_ptr_in;
         rd_ptr_ff      <= rd_ptr_in;
         used_ff        <= used_in;
         asm_started_ff <= asm_started_in;
         fill_ff        <= fill_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // assembly payload and response flags need no reset
   always_ff @(posedge clock) begin
      asm_ff <= asm_in;
      if (req_fire) begin
         rsp_accepted_ff <= rsp_accepted_in;
         rsp_hit_ff      <= rsp_hit_in;
      end
   end

   // message store: one slot per completed message
   mmaq_ram #(
      .WIDTH (MSG_W),
      .DEPTH (MSG_DEPTH)
   ) u_msg_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (asm_in),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   assign rd_msg = msg_type'(ram_rd_data);

   // read data is held by the ram while the response stalls
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accepted    = rsp_accepted_ff;
   assign rsp_msg_valid   = rsp_hit_ff;
   assign rsp_msg_kind    = rsp_hit_ff ? rd_msg.kind        : '0;
   assign rsp_channel     = rsp_hit_ff ? rd_msg.chan        : '0;
   assign rsp_data_count  = rsp_hit_ff ? rd_msg.count       : '0;
   assign rsp_data_first  = rsp_hit_ff ? rd_msg.data_first  : '0;
   assign rsp_data_second = rsp_hit_ff ? rd_msg.data_second : '0;

endmodule

`default_nettype wire

// File: sv/mmaq_checker.sv
// mmaq_checker: port-level assertions for the midi message assembler queue
// depends on mmaq_pkg; bound to midi_message_assembler_queue_unit below
`default_nettype none

module mmaq_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic                         req_operation,
   input wire logic [7:0]                   req_byte_in,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic                         rsp_accepted,
   input wire logic                         rsp_msg_valid,
   input wire logic [mmaq_pkg::KIND_W-1:0]  rsp_msg_kind,
   input wire logic [mmaq_pkg::CHAN_W-1:0]  rsp_channel,
   input wire logic [mmaq_pkg::COUNT_W-1:0] rsp_data_count,
   input wire logic [mmaq_pkg::DATA_W-1:0]  rsp_data_first,
   input wire logic [mmaq_pkg::DATA_W-1:0]  rsp_data_second
);

   import mmaq_pkg::*;

   // a waiting request beat holds its payload until accepted
   a_req_hold : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_ready) |=>
         req_valid && $stable(req_operation) && $stable(req_byte_in))
      else $error("waiting request changed");

   // a push beat never returns a message, a read beat never reports a consumed byte
   a_push_or_read : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_accepted && rsp_msg_valid))
      else $error("response flags both set");

   // a returned message always carries a status kind
   a_kind_status : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_msg_valid) |-> rsp_msg_kind[KIND_W-1])
      else $error("returned message with non-status kind");

   // an empty or push response has every message field at zero
   a_empty_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_msg_valid) |->
         (rsp_msg_kind == '0) && (rsp_channel == '0) && (rsp_data_count == '0) &&
         (rsp_data_first == '0) && (rsp_data_second == '0))
      else $error("non-zero fields without a message");

   // a stalled response beat holds its payload
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         rsp_valid && $stable(rsp_accepted) && $stable(rsp_msg_valid) &&
         $stable(rsp_msg_kind) && $stable(rsp_channel) && $stable(rsp_data_count) &&
         $stable(rsp_data_first) && $stable(rsp_data_second))
      else $error("stalled response changed");

endmodule

bind midi_message_assembler_queue_unit mmaq_checker u_mmaq_checker (.*);

`default_nettype wire
